// File: rtl/imu_bias_calibrate_correct_core_assert.svh
// assertion macros shared by the calibration core modules
// each module that uses them provides clk and rst
`ifndef IMU_BIAS_CALIBRATE_CORRECT_CORE_ASSERT_SVH
`define IMU_BIAS_CALIBRATE_CORRECT_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define IBC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ibc assertion failed");

// antecedent implies consequent in the next cycle
`define IBC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ibc assertion failed");

`endif

// File: rtl/ibc_pkg.sv
// types, widths and helpers for the imu bias calibration core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ibc_pkg;

  localparam int AXIS_W = 16;
  localparam int SUM_W  = 25;
  localparam int CNT_W  = 8;
  localparam int MAG_W  = 24;
  localparam int DIV_K  = 24;
  localparam int DIV_STAGES = 4;

  typedef struct packed {
    logic clear;
    logic add;
    logic divide;
  } lane_ctrl_t;

  typedef struct packed {
    logic signed [AXIS_W-1:0] accel_x_out;
    logic signed [AXIS_W-1:0] accel_y_out;
    logic signed [AXIS_W-1:0] accel_z_out;
    logic signed [AXIS_W-1:0] gyro_x_out;
    logic signed [AXIS_W-1:0] gyro_y_out;
    logic signed [AXIS_W-1:0] gyro_z_out;
    logic                     gyro_cal_busy;
    logic                     accel_cal_busy;
  } result_t;

  function automatic logic signed [AXIS_W-1:0] sat_sub(
    input logic signed [AXIS_W-1:0] a,
    input logic signed [AXIS_W-1:0] b
  );
    logic signed [AXIS_W:0] d;
    d = {a[AXIS_W-1], a} - {b[AXIS_W-1], b};
    if (d[AXIS_W] != d[AXIS_W-1]) begin
      sat_sub = d[AXIS_W] ? {1'b1, {(AXIS_W-1){1'b0}}} : {1'b0, {(AXIS_W-1){1'b1}}};
    end else begin
      sat_sub = d[AXIS_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// File: rtl/ibc_if.sv
// valid/ready channel interfaces for samples and corrected results
// depends on ibc_pkg
`timescale 1ns / 1ps
`default_nettype none

interface ibc_sample_if;
  logic                              valid;
  logic                              ready;
  logic                              mode;
  logic signed [ibc_pkg::AXIS_W-1:0] accel_x_raw;
  logic signed [ibc_pkg::AXIS_W-1:0] accel_y_raw;
  logic signed [ibc_pkg::AXIS_W-1:0] accel_z_raw;
  logic signed [ibc_pkg::AXIS_W-1:0] gyro_x_raw;
  logic signed [ibc_pkg::AXIS_W-1:0] gyro_y_raw;
  logic signed [ibc_pkg::AXIS_W-1:0] gyro_z_raw;

  modport source (
    output valid, mode, accel_x_raw, accel_y_raw, accel_z_raw,
           gyro_x_raw, gyro_y_raw, gyro_z_raw,
    input  ready
  );
  modport sink (
    input  valid, mode, accel_x_raw, accel_y_raw, accel_z_raw,
           gyro_x_raw, gyro_y_raw, gyro_z_raw,
    output ready
  );
endinterface

interface ibc_result_if;
  logic                              valid;
  logic                              ready;
  logic signed [ibc_pkg::AXIS_W-1:0] accel_x_out;
  logic signed [ibc_pkg::AXIS_W-1:0] accel_y_out;
  logic signed [ibc_pkg::AXIS_W-1:0] accel_z_out;
  logic signed [ibc_pkg::AXIS_W-1:0] gyro_x_out;
  logic signed [ibc_pkg::AXIS_W-1:0] gyro_y_out;
  logic signed [ibc_pkg::AXIS_W-1:0] gyro_z_out;
  logic                              gyro_cal_busy;
  logic                              accel_cal_busy;

  modport source (
    output valid, accel_x_out, accel_y_out, accel_z_out,
           gyro_x_out, gyro_y_out, gyro_z_out, gyro_cal_busy, accel_cal_busy,
    input  ready
  );
  modport sink (
    input  valid, accel_x_out, accel_y_out, accel_z_out,
           gyro_x_out, gyro_y_out, gyro_z_out, gyro_cal_busy, accel_cal_busy,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/ibc_phase_ctrl.sv
// calibration phase sequencer: pending flag, sample count, lane commands
// depends on ibc_pkg and the assertion header
`timescale 1ns / 1ps
`default_nettype none

module ibc_phase_ctrl #(
  parameter int SAMPLES = 200
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 accept,
  input  wire                 mode,
  input  wire                 gate,
  output ibc_pkg::lane_ctrl_t ctrl,
  output logic                skip,
  output logic                busy_next
);
  import ibc_pkg::*;
  `include "imu_bias_calibrate_correct_core_assert.svh"

  logic             pending;
  logic             pending_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             active;

  always_comb begin
    active      = gate & (pending | mode);
    ctrl.clear  = active & (count == '0);
    ctrl.add    = active & (count != '0);
    ctrl.divide = ctrl.add & (count >= CNT_W'(SAMPLES));
    skip        = ctrl.clear | ctrl.divide;
    pending_next = ctrl.divide ? 1'b0 : (pending | mode);
    if (ctrl.clear) begin
      count_next = CNT_W'(1);
    end else if (ctrl.divide) begin
      count_next = '0;
    end else if (ctrl.add) begin
      count_next = count + CNT_W'(1);
    end else begin
      count_next = count;
    end
    busy_next = pending_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
      count   <= '0;
    end else if (accept) begin
      pending <= pending_next;
      count   <= count_next;
    end
  end

  `IBC_ASSERT_SAME(a_count_bound, 1'b1, count <= CNT_W'(SAMPLES))
  `IBC_ASSERT_SAME(a_idle_count_zero, !pending, count == '0)
  `IBC_ASSERT_NEXT(a_divide_ends, accept && ctrl.divide, !pending && count == '0)

endmodule

`default_nettype wire

// File: rtl/ibc_lane.sv
// one axis lane: offset correction, accumulation and constant divider pipeline
// depends on ibc_pkg and the assertion header
`timescale 1ns / 1ps
`default_nettype none

module ibc_lane #(
  parameter int SAMPLES = 200
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                accept,
  input  wire                                acc_en,
  input  wire ibc_pkg::lane_ctrl_t           ctrl,
  input  wire signed [ibc_pkg::AXIS_W-1:0]   raw,
  output logic signed [ibc_pkg::AXIS_W-1:0]  corr,
  output logic                               div_busy
);
  import ibc_pkg::*;
  `include "imu_bias_calibrate_correct_core_assert.svh"

  localparam logic [DIV_K:0]   RECIP  = (DIV_K+1)'((64'd1 << DIV_K) / SAMPLES);
  localparam logic [MAG_W-1:0] SAMP_M = MAG_W'(SAMPLES);

  logic signed [AXIS_W-1:0] offset;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  sum_next;
  logic signed [SUM_W-1:0]  sum_neg;
  logic [DIV_STAGES-1:0]    pipe;
  logic                     neg;
  logic [MAG_W-1:0]         mag;
  logic [MAG_W+DIV_K:0]     prod;
  logic [AXIS_W-1:0]        q0;
  logic [AXIS_W-1:0]        q0_s;
  logic [AXIS_W-1:0]        q_fix;
  logic [MAG_W-1:0]         rem;
  logic [MAG_W-1:0]         q0_mul;

  always_comb begin
    corr     = sat_sub(raw, offset);
    sum_next = sum + {{(SUM_W-AXIS_W){corr[AXIS_W-1]}}, corr};
    sum_neg  = -sum;
    q0_s     = prod[DIV_K +: AXIS_W];
    q0_mul   = {{(MAG_W-AXIS_W){1'b0}}, q0_s} * SAMP_M;
    q_fix    = q0 + AXIS_W'(rem >= SAMP_M);
    div_busy = |pipe;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe   <= '0;
      offset <= '0;
      sum    <= '0;
    end else begin
      pipe <= {pipe[DIV_STAGES-2:0], accept & ctrl.divide};
      if (accept && ctrl.clear) begin
        offset <= '0;
        sum    <= '0;
      end else if (accept && ctrl.add && acc_en) begin
        sum <= sum_next;
      end
      if (pipe[DIV_STAGES-1]) begin
        offset <= neg ? -$signed(q_fix) : $signed(q_fix);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pipe[0]) begin
      neg <= sum[SUM_W-1];
      mag <= sum[SUM_W-1] ? sum_neg[MAG_W-1:0] : sum[MAG_W-1:0];
    end
    if (pipe[1]) begin
      prod <= {{(DIV_K+1){1'b0}}, mag} * {{MAG_W{1'b0}}, RECIP};
    end
    if (pipe[2]) begin
      q0  <= q0_s;
      rem <= mag - q0_mul;
    end
  end

  `IBC_ASSERT_SAME(a_pipe_single, 1'b1, $onehot0(pipe))
  `IBC_ASSERT_SAME(a_no_accept_in_divide, div_busy, !accept)
  `IBC_ASSERT_NEXT(a_offset_hold, !(accept && ctrl.clear) && !pipe[DIV_STAGES-1],
                   $stable(offset))
  `IBC_ASSERT_SAME(a_rem_small, pipe[DIV_STAGES-1], rem < (SAMP_M << 1))

endmodule

`default_nettype wire

// File: rtl/ibc_merge.sv
// merging stage: registers the lane results and busy flags as one output transaction
// depends on ibc_pkg, ibc_if and the assertion header
`timescale 1ns / 1ps
`default_nettype none

module ibc_merge (
  input  wire              clk,
  input  wire              rst,
  input  wire              load,
  input  wire ibc_pkg::result_t data,
  output logic             space,
  ibc_result_if.source     result
);
  import ibc_pkg::*;
  `include "imu_bias_calibrate_correct_core_assert.svh"

  logic    valid;
  result_t held;

  always_comb begin
    space                 = !valid | result.ready;
    result.valid          = valid;
    result.accel_x_out    = held.accel_x_out;
    result.accel_y_out    = held.accel_y_out;
    result.accel_z_out    = held.accel_z_out;
    result.gyro_x_out     = held.gyro_x_out;
    result.gyro_y_out     = held.gyro_y_out;
    result.gyro_z_out     = held.gyro_z_out;
    result.gyro_cal_busy  = held.gyro_cal_busy;
    result.accel_cal_busy = held.accel_cal_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (result.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= data;
    end
  end

  `IBC_ASSERT_NEXT(a_load_shows, load, valid)
  `IBC_ASSERT_SAME(a_no_overwrite, valid && !result.ready, !load)
  `IBC_ASSERT_SAME(a_empty_has_space, !valid, space)

endmodule

`default_nettype wire

// File: rtl/imu_bias_calibrate_correct_core.sv
// imu bias calibration and correction, top level
// Usage:
//   sample carries mode and six raw axis samples; result carries the six
//   corrected axes and the two calibration busy flags, one result transaction
//   per sample transaction, in order.
//   Each axis has its own lane: the offset is subtracted with saturation in
//   the cycle of acceptance and the result is registered, so it appears in
//   the cycle after acceptance. One sample is taken per cycle unless stalled.
//   mode 1 arms gyro and accel calibration over SAMPLES samples each; accel
//   skips the samples on which gyro clears or divides. On the sample that
//   ends a phase, the new offsets come from a four-stage reciprocal divider
//   in each lane, and sample.ready stays low while that divider runs.
//   If the receiver stalls, the output register holds its result and
//   sample.ready follows result.ready, so nothing is dropped.
//   Reset (rst, synchronous) clears offsets, sums, counts, pending flags and
//   the output register; the block is ready as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none

module imu_bias_calibrate_correct_core #(
  parameter int SAMPLES = 200
) (
  input  wire          clk,
  input  wire          rst,
  ibc_sample_if.sink   sample,
  ibc_result_if.source result
);
  import ibc_pkg::*;

  logic               accept;
  logic               space;
  logic [5:0]         busy_lane;
  lane_ctrl_t         gyro_ctrl;
  lane_ctrl_t         accel_ctrl;
  logic               gyro_skip;
  logic               accel_skip;
  logic               gyro_busy;
  logic               accel_busy;
  logic signed [AXIS_W-1:0] ax_c, ay_c, az_c, gx_c, gy_c, gz_c;
  result_t            merged;

  assign sample.ready = space & ~(|busy_lane);
  assign accept       = sample.valid & sample.ready;

  ibc_phase_ctrl #(.SAMPLES(SAMPLES)) u_gyro_ctrl (
    .clk(clk), .rst(rst), .accept(accept), .mode(sample.mode), .gate(1'b1),
    .ctrl(gyro_ctrl), .skip(gyro_skip), .busy_next(gyro_busy)
  );

  ibc_phase_ctrl #(.SAMPLES(SAMPLES)) u_accel_ctrl (
    .clk(clk), .rst(rst), .accept(accept), .mode(sample.mode), .gate(~gyro_skip),
    .ctrl(accel_ctrl), .skip(accel_skip), .busy_next(accel_busy)
  );

  ibc_lane #(.SAMPLES(SAMPLES)) u_lane_ax (
    .clk(clk), .rst(rst), .accept(accept), .acc_en(1'b1), .ctrl(accel_ctrl),
    .raw(sample.accel_x_raw), .corr(ax_c), .div_busy(busy_lane[0])
  );
  ibc_lane #(.SAMPLES(SAMPLES)) u_lane_ay (
    .clk(clk), .rst(rst), .accept(accept), .acc_en(1'b1), .ctrl(accel_ctrl),
    .raw(sample.accel_y_raw), .corr(ay_c), .div_busy(busy_lane[1])
  );
  // accel z is cleared but never summed, so its offset ends at zero
  ibc_lane #(.SAMPLES(SAMPLES)) u_lane_az (
    .clk(clk), .rst(rst), .accept(accept), .acc_en(1'b0), .ctrl(accel_ctrl),
    .raw(sample.accel_z_raw), .corr(az_c), .div_busy(busy_lane[2])
  );
  ibc_lane #(.SAMPLES(SAMPLES)) u_lane_gx (
    .clk(clk), .rst(rst), .accept(accept), .acc_en(1'b1), .ctrl(gyro_ctrl),
    .raw(sample.gyro_x_raw), .corr(gx_c), .div_busy(busy_lane[3])
  );
  ibc_lane #(.SAMPLES(SAMPLES)) u_lane_gy (
    .clk(clk), .rst(rst), .accept(accept), .acc_en(1'b1), .ctrl(gyro_ctrl),
    .raw(sample.gyro_y_raw), .corr(gy_c), .div_busy(busy_lane[4])
  );
  ibc_lane #(.SAMPLES(SAMPLES)) u_lane_gz (
    .clk(clk), .rst(rst), .accept(accept), .acc_en(1'b1), .ctrl(gyro_ctrl),
    .raw(sample.gyro_z_raw), .corr(gz_c), .div_busy(busy_lane[5])
  );

  always_comb begin
    merged.accel_x_out    = ax_c;
    merged.accel_y_out    = ay_c;
    merged.accel_z_out    = az_c;
    merged.gyro_x_out     = gx_c;
    merged.gyro_y_out     = gy_c;
    merged.gyro_z_out     = gz_c;
    merged.gyro_cal_busy  = gyro_busy;
    merged.accel_cal_busy = accel_busy;
  end

  ibc_merge u_merge (
    .clk(clk), .rst(rst), .load(accept), .data(merged), .space(space),
    .result(result)
  );

  `include "imu_bias_calibrate_correct_core_assert.svh"

  `IBC_ASSERT_SAME(a_phases_exclusive, accept, !(gyro_skip && accel_skip))
  `IBC_ASSERT_SAME(a_accel_waits, gyro_skip, !(accel_ctrl.add || accel_ctrl.clear))
  `IBC_ASSERT_SAME(a_lanes_busy_together, 1'b1,
                   (busy_lane[5:3] == 3'b000 || busy_lane[5:3] == 3'b111) &&
                   (busy_lane[2:0] == 3'b000 || busy_lane[2:0] == 3'b111))

endmodule

`default_nettype wire

// File: dv/tb.sv
// testbench for imu_bias_calibrate_correct_core: drives raw imu samples, predicts
// corrected axes and busy flags in a scoreboard class and checks every result transaction
// depends on rtl/ibc_pkg.sv, rtl/ibc_if.sv and rtl/imu_bias_calibrate_correct_core.sv
`timescale 1ns / 1ps

module tb;
  import ibc_pkg::*;

  localparam int CAL_SAMPLES  = 200;
  localparam int NUM_SAMPLES  = 1800;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 250;

  typedef struct packed {
    logic                     mode;
    logic signed [AXIS_W-1:0] ax;
    logic signed [AXIS_W-1:0] ay;
    logic signed [AXIS_W-1:0] az;
    logic signed [AXIS_W-1:0] gx;
    logic signed [AXIS_W-1:0] gy;
    logic signed [AXIS_W-1:0] gz;
  } sample_t;

  class imu_cal_tracker;
    logic signed [AXIS_W-1:0] gyro_ofs[3];
    logic signed [AXIS_W-1:0] accel_ofs[3];
    logic signed [SUM_W-1:0]  gyro_acc[3];
    logic signed [SUM_W-1:0]  accel_acc[3];
    logic [CNT_W-1:0]         gyro_n;
    logic [CNT_W-1:0]         accel_n;
    logic                     gyro_armed;
    logic                     accel_armed;
    result_t                  corrected_q[$];
    int                       errors;

    function new();
      for (int i = 0; i < 3; i++) begin
        gyro_ofs[i] = '0;
        accel_ofs[i] = '0;
        gyro_acc[i] = '0;
        accel_acc[i] = '0;
      end
      gyro_n = '0;
      accel_n = '0;
      gyro_armed = 1'b0;
      accel_armed = 1'b0;
      errors = 0;
    endfunction

    function logic signed [AXIS_W-1:0] remove_bias(logic signed [AXIS_W-1:0] raw,
                                                   logic signed [AXIS_W-1:0] ofs);
      int d;
      d = int'(raw) - int'(ofs);
      if (d > 32767) d = 32767;
      if (d < -32768) d = -32768;
      return d[AXIS_W-1:0];
    endfunction

    function void note_sample(sample_t s);
      logic signed [AXIS_W-1:0] ra[3];
      logic signed [AXIS_W-1:0] rg[3];
      logic signed [AXIS_W-1:0] a[3];
      logic signed [AXIS_W-1:0] g[3];
      logic                     skip_accel;
      result_t                  r;
      ra = '{s.ax, s.ay, s.az};
      rg = '{s.gx, s.gy, s.gz};
      if (s.mode) begin
        gyro_armed = 1'b1;
        accel_armed = 1'b1;
      end
      for (int i = 0; i < 3; i++) begin
        a[i] = remove_bias(ra[i], accel_ofs[i]);
        g[i] = remove_bias(rg[i], gyro_ofs[i]);
      end
      r.accel_x_out = a[0];
      r.accel_y_out = a[1];
      r.accel_z_out = a[2];
      r.gyro_x_out = g[0];
      r.gyro_y_out = g[1];
      r.gyro_z_out = g[2];

      // gyro phase first, it may hold off the accel phase for this transaction
      skip_accel = 1'b0;
      if (gyro_armed) begin
        if (gyro_n == 0) begin
          for (int i = 0; i < 3; i++) begin
            gyro_ofs[i] = '0;
            gyro_acc[i] = '0;
          end
          gyro_n = CNT_W'(1);
          skip_accel = 1'b1;
        end else begin
          for (int i = 0; i < 3; i++) gyro_acc[i] = gyro_acc[i] + g[i];
          if (gyro_n >= CAL_SAMPLES) begin
            for (int i = 0; i < 3; i++) gyro_ofs[i] = AXIS_W'(gyro_acc[i] / CAL_SAMPLES);
            gyro_n = '0;
            gyro_armed = 1'b0;
            skip_accel = 1'b1;
          end else begin
            gyro_n = gyro_n + CNT_W'(1);
          end
        end
      end

      // accel phase never accumulates z
      if (!skip_accel && accel_armed) begin
        if (accel_n == 0) begin
          for (int i = 0; i < 3; i++) begin
            accel_ofs[i] = '0;
            accel_acc[i] = '0;
          end
          accel_n = CNT_W'(1);
        end else begin
          accel_acc[0] = accel_acc[0] + a[0];
          accel_acc[1] = accel_acc[1] + a[1];
          if (accel_n >= CAL_SAMPLES) begin
            for (int i = 0; i < 3; i++) accel_ofs[i] = AXIS_W'(accel_acc[i] / CAL_SAMPLES);
            accel_n = '0;
            accel_armed = 1'b0;
          end else begin
            accel_n = accel_n + CNT_W'(1);
          end
        end
      end

      r.gyro_cal_busy = gyro_armed;
      r.accel_cal_busy = accel_armed;
      corrected_q.push_back(r);
    endfunction

    function void compare_field(string field, int want, int got);
      if (want != got) begin
        $display("%0t %s expected %0d actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (corrected_q.size() == 0) begin
        $display("%0t unexpected result transaction, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = corrected_q.pop_front();
      compare_field("accel_x_out", want.accel_x_out, got.accel_x_out);
      compare_field("accel_y_out", want.accel_y_out, got.accel_y_out);
      compare_field("accel_z_out", want.accel_z_out, got.accel_z_out);
      compare_field("gyro_x_out", want.gyro_x_out, got.gyro_x_out);
      compare_field("gyro_y_out", want.gyro_y_out, got.gyro_y_out);
      compare_field("gyro_z_out", want.gyro_z_out, got.gyro_z_out);
      compare_field("gyro_cal_busy", want.gyro_cal_busy, got.gyro_cal_busy);
      compare_field("accel_cal_busy", want.accel_cal_busy, got.accel_cal_busy);
    endfunction

    function int pending();
      return corrected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  int   n_taken;
  int   n_results;
  int   stall_cycles;

  imu_cal_tracker tracker;

  ibc_sample_if sample_ch ();
  ibc_result_if result_ch ();

  imu_bias_calibrate_correct_core #(
    .SAMPLES(CAL_SAMPLES)
  ) u_top (
    .clk   (clk),
    .rst   (rst),
    .sample(sample_ch.sink),
    .result(result_ch.source)
  );

  always #5 clk = ~clk;

  function automatic logic signed [AXIS_W-1:0] clip16(int v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[AXIS_W-1:0];
  endfunction

  function automatic logic signed [AXIS_W-1:0] near(int bias, int spread);
    return clip16(bias + int'($urandom_range(2 * spread)) - spread);
  endfunction

  function automatic int pick_bias();
    case ($urandom_range(5))
      0: return 32767;
      1: return -32768;
      2: return 0;
      3, 4: return int'($urandom_range(4000)) - 2000;
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  function automatic logic signed [AXIS_W-1:0] wild_axis();
    case ($urandom_range(7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      default: return AXIS_W'($urandom());
    endcase
  endfunction

  function automatic sample_t uniform(logic mode, logic signed [AXIS_W-1:0] v);
    return '{mode, v, v, v, v, v, v};
  endfunction

  task automatic offer_sample(input sample_t s);
    logic taken;
    // no gaps on the sender side for a stretch in the middle
    while ((n_taken < 700 || n_taken >= 1000) && $urandom_range(99) < 21) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.mode <= s.mode;
    sample_ch.accel_x_raw <= s.ax;
    sample_ch.accel_y_raw <= s.ay;
    sample_ch.accel_z_raw <= s.az;
    sample_ch.gyro_x_raw <= s.gx;
    sample_ch.gyro_y_raw <= s.gy;
    sample_ch.gyro_z_raw <= s.gz;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = sample_ch.ready;
      if (taken) tracker.note_sample(s);
      @(posedge clk);
    end
    n_taken++;
  endtask

  // arm, then feed a biased sample set a little longer than both phases need
  task automatic calibration_run();
    int      bias[6];
    int      spread;
    int      len;
    sample_t s;
    for (int i = 0; i < 6; i++) bias[i] = pick_bias();
    case ($urandom_range(3))
      0: spread = 0;
      1: spread = 20;
      2: spread = 500;
      default: spread = 8000;
    endcase
    len = CAL_SAMPLES + 3 + $urandom_range(4);
    for (int k = 0; k <= len; k++) begin
      s.mode = (k == 0) || ($urandom_range(149) == 0);
      s.ax = near(bias[0], spread);
      s.ay = near(bias[1], spread);
      s.az = near(bias[2], spread);
      s.gx = near(bias[3], spread);
      s.gy = near(bias[4], spread);
      s.gz = near(bias[5], spread);
      offer_sample(s);
    end
  endtask

  task automatic free_burst();
    int      len;
    sample_t s;
    len = $urandom_range(80, 20);
    for (int k = 0; k < len; k++) begin
      s.mode = ($urandom_range(199) == 0);
      s.ax = wild_axis();
      s.ay = wild_axis();
      s.az = wild_axis();
      s.gx = wild_axis();
      s.gy = wild_axis();
      s.gz = wild_axis();
      offer_sample(s);
    end
  endtask

  initial begin
    tracker = new();
    clk = 1'b0;
    rst = 1'b1;
    n_taken = 0;
    n_results = 0;
    stall_cycles = 0;
    sample_ch.valid = 1'b0;
    sample_ch.mode = 1'b0;
    sample_ch.accel_x_raw = '0;
    sample_ch.accel_y_raw = '0;
    sample_ch.accel_z_raw = '0;
    sample_ch.gyro_x_raw = '0;
    sample_ch.gyro_y_raw = '0;
    sample_ch.gyro_z_raw = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // field extremes, bit patterns, then arming and re-arming on the clearing step
    offer_sample(uniform(1'b0, 16'sh0000));
    offer_sample(uniform(1'b0, 16'sh7fff));
    offer_sample(uniform(1'b0, 16'sh8000));
    offer_sample('{1'b0, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa});
    offer_sample('{1'b0, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555});
    offer_sample(uniform(1'b0, 16'sh0001));
    offer_sample(uniform(1'b0, 16'shffff));
    offer_sample(uniform(1'b1, 16'sh7fff));
    offer_sample(uniform(1'b1, 16'sh8000));
    for (int k = 0; k < 4; k++) offer_sample(uniform(1'b0, 16'sh7fff));

    while (n_taken < NUM_SAMPLES) begin
      if ($urandom_range(2) != 0) calibration_run();
      else free_burst();
    end

    sample_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("imu_bias_calibrate_correct_core: match");
    end else begin
      $display("imu_bias_calibrate_correct_core: mismatch");
    end
    $finish;
  end

  initial begin : receiver
    int      hold_left;
    logic    held;
    result_t got;
    hold_left = 0;
    held = 1'b0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && n_results >= HOLD_AT) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        result_ch.ready <= 1'b0;
        hold_left--;
      end else if (n_results >= 700 && n_results < 1000) begin
        result_ch.ready <= 1'b1;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= 21);
      end
      @(negedge clk);
      if (result_ch.valid && result_ch.ready) begin
        got = {result_ch.accel_x_out, result_ch.accel_y_out, result_ch.accel_z_out,
               result_ch.gyro_x_out, result_ch.gyro_y_out, result_ch.gyro_z_out,
               result_ch.gyro_cal_busy, result_ch.accel_cal_busy};
        tracker.check_result(got);
        n_results++;
      end
    end
  end

  always @(negedge clk) begin
    if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles = stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("imu_bias_calibrate_correct_core: mismatch");
      $finish;
    end
  end

endmodule
